>>> sv/dpbt_pkg.sv
// shared types and op codes for the dirty page bitmap tracker
package dpbt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam int PAGE_W = 36;
    localparam int TIME_W = 64;

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] range_end;
        logic [TIME_W-1:0] timestamp;
    } cmd_t;

endpackage

>>> sv/dpbt_front.sv
// command capture and two-entry queue toward the execution engine
module dpbt_front
    import dpbt_pkg::*;
#(
    parameter int PAGE_NUMBER_BITS = 36
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  op,
    input  logic [PAGE_W-1:0]           page,
    input  logic [PAGE_W-1:0]           range_end,
    input  logic [TIME_W-1:0]           timestamp,
    output logic                        busy,
    output logic                        q_valid,
    output cmd_t                        q_cmd,
    input  logic                        q_pop
);
    localparam logic [PAGE_W-1:0] PMASK = PAGE_W'((65'd1 << PAGE_NUMBER_BITS) - 65'd1);

    cmd_t       fifo_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       cin;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rp_reg];

    always_comb
    begin
        cin.op        = op;
        cin.page      = page & PMASK;
        cin.range_end = range_end & PMASK;
        cin.timestamp = timestamp;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= cin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

>>> sv/dpbt_back.sv
// execution engine: slot tags, bitmap and timestamp memories, scan sequencer
module dpbt_back
    import dpbt_pkg::*;
#(
    parameter int BLOCK_SLOTS      = 8,
    parameter int PAGES_IN_BLOCK   = 512,
    parameter int PAGE_NUMBER_BITS = 36
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              done,
    output logic              status,
    output logic              found,
    output logic [PAGE_W-1:0] page_out,
    output logic [TIME_W-1:0] time_out
);
    localparam int SH    = $clog2(PAGES_IN_BLOCK);
    localparam int TAG_W = PAGE_NUMBER_BITS - SH;
    localparam int SW    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
    localparam int WORD  = 64;
    localparam int WPB   = PAGES_IN_BLOCK / WORD;
    localparam int WW    = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int BW    = $clog2(WORD);
    localparam int MD    = BLOCK_SLOTS * WPB;
    localparam int MA    = SW + WW;
    localparam int TD    = BLOCK_SLOTS * PAGES_IN_BLOCK;
    localparam int TA    = SW + SH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MATCH = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SLOT  = 4'd5;
    localparam logic [3:0] S_WRD   = 4'd6;
    localparam logic [3:0] S_WCHK  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TOUT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          st_reg, st_next;
    cmd_t                c_reg;
    logic [BLOCK_SLOTS-1:0] used_reg;
    logic [TAG_W-1:0]    tag_mem [BLOCK_SLOTS];
    logic [WORD-1:0]     bmp_mem [MD];
    logic [TIME_W-1:0]   ts_mem  [TD];
    logic [WORD-1:0]     bmp_q;
    logic [TIME_W-1:0]   ts_q;

    logic [SW-1:0]       slot_reg;
    logic [WW-1:0]       w_reg;
    logic [SW:0]         scan_reg;
    logic                have_reg;
    logic [PAGE_W-1:0]   best_reg;
    logic [TA-1:0]       best_ta_reg;
    logic                status_reg, found_reg;

    logic [TAG_W-1:0]    tag, etag, stag;
    logic [SH-1:0]       bit_i, ebit;
    logic [SW-1:0]       hit_i, free_i;
    logic                hit_any, free_any;

    assign tag   = TAG_W'(c_reg.page >> SH);
    assign bit_i = c_reg.page[SH-1:0];
    assign etag  = TAG_W'(c_reg.range_end >> SH);
    assign ebit  = c_reg.range_end[SH-1:0];
    assign stag  = tag_mem[scan_reg[SW-1:0]];

    always_comb
    begin
        hit_any  = 1'b0;
        hit_i    = '0;
        free_any = 1'b0;
        free_i   = '0;
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--)
        begin
            if (used_reg[i] && tag_mem[i] == tag)
            begin
                hit_any = 1'b1;
                hit_i   = SW'(i);
            end
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_i   = SW'(i);
            end
        end
    end

    // scan window masks for the current word
    logic [WORD-1:0] lo_m, hi_m, wm;
    logic [BW-1:0]   lz;
    logic            wany;
    logic [SH-1:0]   wbase;
    assign wbase = {w_reg, {BW{1'b0}}};

    always_comb
    begin
        lo_m = '1;
        hi_m = '1;
        if (stag == tag && w_reg == WW'(bit_i >> BW))
        begin
            lo_m = {WORD{1'b1}} << bit_i[BW-1:0];
        end
        if (stag == etag && w_reg == WW'(ebit >> BW))
        begin
            hi_m = {WORD{1'b1}} >> (BW'(WORD - 1) - ebit[BW-1:0]);
        end
        wm   = bmp_q & lo_m & hi_m;
        wany = |wm;
        lz   = '0;
        for (int b = WORD - 1; b >= 0; b--)
        begin
            if (wm[b])
            begin
                lz = BW'(b);
            end
        end
    end

    logic [WW-1:0] w_first, w_last;
    assign w_first = (stag == tag)  ? WW'(bit_i >> BW) : '0;
    assign w_last  = (stag == etag) ? WW'(ebit >> BW)  : WW'(WPB - 1);

    logic [PAGE_W-1:0] cand;
    assign cand = PAGE_W'({stag, w_reg, lz});

    logic              bm_we;
    logic [MA-1:0]     bm_wa, bm_ra;
    logic [WW-1:0]     bm_rw;
    logic [WORD-1:0]   bm_wd;
    logic              ts_we;

    // while checking a word, fetch the next one so data keeps pace with w_reg
    assign bm_rw = (st_reg == S_WCHK) ? w_reg + 1'b1 : w_reg;
    assign bm_ra = {((st_reg == S_SLOT || st_reg == S_WRD || st_reg == S_WCHK) ?
                     scan_reg[SW-1:0] : slot_reg), bm_rw};
    assign ts_we = (st_reg == S_CHK) && (c_reg.op == OP_INSERT) && !bmp_q[bit_i[BW-1:0]];

    always_comb
    begin
        bm_we = 1'b0;
        bm_wa = {slot_reg, w_reg};
        bm_wd = '0;
        if (st_reg == S_CLR)
        begin
            bm_we = 1'b1;
        end
        else if (ts_we)
        begin
            bm_we = 1'b1;
            bm_wd = bmp_q | (WORD'(1) << bit_i[BW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bmp_mem[bm_wa] <= bm_wd;
        end
        bmp_q <= bmp_mem[bm_ra];
        if (ts_we)
        begin
            ts_mem[{slot_reg, bit_i}] <= c_reg.timestamp;
        end
        ts_q <= ts_mem[(st_reg == S_TRD) ? best_ta_reg : {slot_reg, bit_i}];
        if (st_reg == S_MATCH && c_reg.op == OP_INSERT && !hit_any && free_any)
        begin
            tag_mem[free_i] <= tag;
        end
        if (st_reg == S_IDLE && q_valid)
        begin
            c_reg <= q_cmd;
        end
    end

    assign q_pop = (st_reg == S_IDLE) && q_valid;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (q_valid) st_next = S_MATCH;
            S_MATCH:
            begin
                case (c_reg.op)
                    OP_INSERT: st_next = hit_any ? S_RD : (free_any ? S_CLR : S_OUT);
                    OP_LOOKUP: st_next = hit_any ? S_RD : S_OUT;
                    OP_FIND:   st_next = (c_reg.page <= c_reg.range_end) ? S_SLOT : S_OUT;
                    default:   st_next = S_OUT;
                endcase
            end
            S_CLR:   if (w_reg == WW'(WPB - 1)) st_next = S_RD;
            S_RD:    st_next = S_CHK;
            S_CHK:   st_next = (c_reg.op == OP_LOOKUP) ? S_TOUT : S_OUT;
            S_SLOT:
            begin
                if (scan_reg == (SW+1)'(BLOCK_SLOTS))
                    st_next = have_reg ? S_TRD : S_OUT;
                else if (used_reg[scan_reg[SW-1:0]] && stag >= tag && stag <= etag)
                    st_next = S_WRD;
            end
            S_WRD:   st_next = S_WCHK;
            S_WCHK:
            begin
                if (wany || w_reg == w_last) st_next = S_SLOT;
                else st_next = S_WCHK;
            end
            S_TRD:   st_next = S_TOUT;
            S_TOUT:  st_next = S_OUT;
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            used_reg   <= '0;
            slot_reg   <= '0;
            w_reg      <= '0;
            scan_reg   <= '0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
            best_ta_reg <= '0;
            status_reg <= 1'b0;
            found_reg  <= 1'b0;
            time_out   <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                S_IDLE:
                begin
                    status_reg <= 1'b0;
                    found_reg  <= 1'b0;
                    have_reg   <= 1'b0;
                    scan_reg   <= '0;
                    time_out   <= '0;
                    w_reg      <= '0;
                end
                S_MATCH:
                begin
                    slot_reg <= hit_any ? hit_i : free_i;
                    w_reg    <= hit_any ? WW'(bit_i >> BW) : '0;
                    if (c_reg.op == OP_INSERT && !hit_any)
                    begin
                        if (free_any)
                            used_reg[free_i] <= 1'b1;
                        else
                            status_reg <= 1'b1;
                    end
                end
                S_CLR:
                begin
                    w_reg <= (w_reg == WW'(WPB - 1)) ? WW'(bit_i >> BW) : w_reg + 1'b1;
                end
                S_CHK:
                begin
                    if (c_reg.op == OP_LOOKUP)
                        found_reg <= bmp_q[bit_i[BW-1:0]];
                end
                S_SLOT:
                begin
                    if (scan_reg != (SW+1)'(BLOCK_SLOTS))
                    begin
                        w_reg <= w_first;
                        if (!(used_reg[scan_reg[SW-1:0]] && stag >= tag && stag <= etag))
                            scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_WRD: ;
                S_WCHK:
                begin
                    if (wany)
                    begin
                        if (!have_reg || cand < best_reg)
                        begin
                            have_reg    <= 1'b1;
                            best_reg    <= cand;
                            best_ta_reg <= {scan_reg[SW-1:0], SH'(wbase) | SH'(lz)};
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                    else if (w_reg == w_last)
                        scan_reg <= scan_reg + 1'b1;
                    else
                        w_reg <= w_reg + 1'b1;
                end
                S_TRD:   found_reg <= 1'b1;
                S_TOUT:  if (found_reg) time_out <= ts_q;
                default: ;
            endcase
        end
    end

    assign done     = (st_reg == S_OUT);
    assign status   = status_reg;
    assign found    = found_reg;
    assign page_out = (c_reg.op == OP_FIND && found_reg) ? best_reg : c_reg.page;

endmodule

>>> sv/dirty_page_block_bitmap_tracker.sv
// top level of the dirty page bitmap tracker
//
// usage: drive op, page, range_end and timestamp with start high; an item is
// taken on a clock edge where start is high and busy is low. a two-entry
// queue holds items while the engine works, so busy only rises when it fills.
// each item yields one result shown for one cycle with done high; the receiver
// cannot stall it. items complete in order.
// an insert or lookup on a known block reads and checks its bitmap word; an
// insert that claims a new slot first clears each 64-bit bitmap word of it
// (PAGES_IN_BLOCK/64 words). find walks the slots in order, passing unused or
// out-of-range ones one per cycle, and reads bitmap words one per cycle
// through the single bitmap read port.
// reset clears the slot-used flags and the queue; bitmaps are cleared when a
// slot is claimed, so no clearing pass follows reset.
module dirty_page_block_bitmap_tracker
    import dpbt_pkg::*;
#(
    parameter int BLOCK_SLOTS      = 8,
    parameter int PAGES_IN_BLOCK   = 512,
    parameter int PAGE_NUMBER_BITS = 36
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [PAGE_W-1:0] page,
    input  logic [PAGE_W-1:0] range_end,
    input  logic [TIME_W-1:0] timestamp,
    output logic              done,
    output logic              status,
    output logic              found,
    output logic [PAGE_W-1:0] page_out,
    output logic [TIME_W-1:0] time_out
);
    logic q_valid, q_pop;
    cmd_t q_cmd;

    dpbt_front #(.PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .page(page),
        .range_end(range_end), .timestamp(timestamp), .busy(busy),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    dpbt_back #(
        .BLOCK_SLOTS(BLOCK_SLOTS),
        .PAGES_IN_BLOCK(PAGES_IN_BLOCK),
        .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)
    ) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_pop(q_pop), .done(done), .status(status), .found(found),
        .page_out(page_out), .time_out(time_out)
    );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the dirty page bitmap tracker
`timescale 1ns / 1ps

module tb_top;
    import dpbt_pkg::*;

    localparam int SLOTS = 8;
    localparam int BLK_PAGES = 512;
    localparam int SH = 9;
    localparam int TAG_W = PAGE_W - SH;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_RANDOM = 500;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [PAGE_W-1:0] page_out;
        logic [TIME_W-1:0] time_out;
    } answer_t;

    typedef struct {
        cmd_t    cmd;
        logic    typed;
        answer_t ans;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        op = '0;
    logic [PAGE_W-1:0] page = '0;
    logic [PAGE_W-1:0] range_end = '0;
    logic [TIME_W-1:0] timestamp = '0;
    logic              done;
    logic              status;
    logic              found;
    logic [PAGE_W-1:0] page_out;
    logic [TIME_W-1:0] time_out;

    // tracker copy
    logic              slot_busy [SLOTS];
    logic [TAG_W-1:0]  slot_tag [SLOTS];
    logic [BLK_PAGES-1:0] dirty_map [SLOTS];
    logic [TIME_W-1:0] write_time [SLOTS][BLK_PAGES];

    answer_t pending_answers[$];
    int      error_count = 0;
    int      send_idle_pct = 0;

    dirty_page_block_bitmap_tracker i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .page(page), .range_end(range_end), .timestamp(timestamp),
        .done(done), .status(status), .found(found),
        .page_out(page_out), .time_out(time_out)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int find_slot(input logic [TAG_W-1:0] tag);
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i] && slot_tag[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic answer_t track_item(input cmd_t c);
        answer_t a;
        logic [TAG_W-1:0] tag, last_tag;
        int bit_idx, s, lo, hi;
        logic have;
        logic [PAGE_W-1:0] cand_page;
        tag = c.page[PAGE_W-1:SH];
        bit_idx = c.page[SH-1:0];
        a = '{status: 1'b0, found: 1'b0, page_out: c.page, time_out: '0};
        have = 1'b0;
        if (c.op == OP_INSERT)
        begin
            s = find_slot(tag);
            if (s < 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_busy[i])
                    begin
                        s = i;
                        break;
                    end
                if (s >= 0)
                begin
                    slot_busy[s] = 1'b1;
                    slot_tag[s] = tag;
                    dirty_map[s] = '0;
                end
            end
            if (s < 0)
                a.status = 1'b1;
            else if (!dirty_map[s][bit_idx])
            begin
                dirty_map[s][bit_idx] = 1'b1;
                write_time[s][bit_idx] = c.timestamp;
            end
        end
        else if (c.op == OP_LOOKUP)
        begin
            s = find_slot(tag);
            if (s >= 0 && dirty_map[s][bit_idx])
            begin
                a.found = 1'b1;
                a.time_out = write_time[s][bit_idx];
            end
        end
        else if (c.op == OP_FIND && c.page <= c.range_end)
        begin
            last_tag = c.range_end[PAGE_W-1:SH];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_busy[i] || slot_tag[i] < tag || slot_tag[i] > last_tag)
                    continue;
                lo = (slot_tag[i] == tag) ? bit_idx : 0;
                hi = (slot_tag[i] == last_tag) ? int'(c.range_end[SH-1:0]) : BLK_PAGES - 1;
                for (int b = lo; b <= hi; b++)
                    if (dirty_map[i][b])
                    begin
                        cand_page = {slot_tag[i], b[SH-1:0]};
                        if (!have || cand_page < a.page_out)
                        begin
                            have = 1'b1;
                            a.page_out = cand_page;
                            a.time_out = write_time[i][b];
                        end
                        break;
                    end
            end
            a.found = have;
        end
        return a;
    endfunction

    // results are checked in order at each done strobe
    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                w = pending_answers.pop_front();
                if (status !== w.status)
                    report_mismatch("status", status, w.status);
                if (found !== w.found)
                    report_mismatch("found", found, w.found);
                if (page_out !== w.page_out)
                    report_mismatch("page_out", page_out, w.page_out);
                if (time_out !== w.time_out)
                    report_mismatch("time_out", time_out, w.time_out);
            end
        end
    end

    task automatic send_item(input cmd_t c, input logic typed, input answer_t ans);
        answer_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= c.op;
        page <= c.page;
        range_end <= c.range_end;
        timestamp <= c.timestamp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = track_item(c);
        if (typed && p !== ans)
        begin
            $display("table row disagrees with tracker copy for page %h", c.page);
            error_count++;
        end
        pending_answers.push_back(typed ? ans : p);
    endtask

    // pages cluster on a few block tags so slots fill and hits are common
    function automatic logic [PAGE_W-1:0] pick_page();
        logic [TAG_W-1:0] tag;
        case ($urandom_range(9))
            0: tag = TAG_W'({$urandom, $urandom});
            1: tag = TAG_W'({TAG_W{1'b1}} - $urandom_range(3));
            default: tag = TAG_W'($urandom_range(11));
        endcase
        return {tag, 9'($urandom_range(BLK_PAGES - 1))};
    endfunction

    initial
    begin
        row_t rows[$];
        cmd_t c;
        answer_t z;
        logic [PAGE_W-1:0] top_page;
        top_page = {PAGE_W{1'b1}};
        z = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;
        rows = '{
            '{'{OP_LOOKUP, 36'd0, 36'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 36'd0, 64'd0}},
            '{'{OP_FIND, 36'd0, top_page, 64'd0}, 1'b1, '{1'b0, 1'b0, 36'd0, 64'd0}},
            '{'{OP_INSERT, 36'd0, 36'd0, 64'h0123}, 1'b1, '{1'b0, 1'b0, 36'd0, 64'd0}},
            '{'{OP_INSERT, 36'd0, 36'd0, 64'h9999}, 1'b1, '{1'b0, 1'b0, 36'd0, 64'd0}},
            '{'{OP_LOOKUP, 36'd0, 36'd0, 64'd0}, 1'b1, '{1'b0, 1'b1, 36'd0, 64'h0123}},
            '{'{OP_INSERT, top_page, 36'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
              '{1'b0, 1'b0, top_page, 64'd0}},
            '{'{OP_LOOKUP, top_page, top_page, 64'd5}, 1'b1,
              '{1'b0, 1'b1, top_page, 64'hFFFF_FFFF_FFFF_FFFF}},
            '{'{OP_FIND, 36'd1, top_page, 64'd0}, 1'b0, z},
            '{'{OP_FIND, 36'd5, 36'd4, 64'd0}, 1'b1, '{1'b0, 1'b0, 36'd5, 64'd0}},
            '{'{OP_UNUSED, 36'h5_5555_5555, top_page, 64'hAAAA}, 1'b1,
              '{1'b0, 1'b0, 36'h5_5555_5555, 64'd0}},
            '{'{OP_INSERT, 36'h0_0000_03FF, 36'd0, 64'h11}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_0400, 36'd0, 64'h22}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_0600, 36'd0, 64'h33}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_0800, 36'd0, 64'h44}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_0A00, 36'd0, 64'h55}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_0C00, 36'd0, 64'h66}, 1'b0, z},
            '{'{OP_INSERT, 36'hA_AAAA_AAAA, 36'd0, 64'h77}, 1'b0, z},
            '{'{OP_INSERT, 36'h0_0000_1000, 36'd0, 64'h88}, 1'b1,
              '{1'b1, 1'b0, 36'h0_0000_1000, 64'd0}},
            '{'{OP_FIND, 36'h0_0000_0201, 36'h0_0000_0BFF, 64'd0}, 1'b0, z},
            '{'{OP_FIND, 36'h0_0000_0401, top_page, 64'd0}, 1'b0, z},
            '{'{OP_LOOKUP, 36'h0_0000_03FF, 36'd0, 64'd0}, 1'b0, z}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].typed, rows[i].ans);
        // random part, with a reset-free clear of state impossible, so slots stay
        // mostly full and pages on new tags exercise the no-memory path
        for (int k = 0; k < N_RANDOM; k++)
        begin
            case (k / 125)
                0: send_idle_pct = 0;
                1: send_idle_pct = 59;
                2: send_idle_pct = 12;
                default: send_idle_pct = $urandom_range(1) ? 0 : 59;
            endcase
            c.op = 2'($urandom_range(20) == 0 ? OP_UNUSED : $urandom_range(2));
            c.page = pick_page();
            c.range_end = $urandom_range(3) == 0 ? PAGE_W'({$urandom, $urandom})
                                                  : PAGE_W'(c.page + $urandom_range(2000));
            c.timestamp = {$urandom, $urandom};
            send_item(c, 1'b0, z);
        end
        start <= 1'b0;
        for (int w = 0; w < 20000 && pending_answers.size() != 0; w++)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
